### src/fpdd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the flash pulse digit decoder.
// No dependencies; imported by every module of the block.
package fpdd_pkg;

  localparam int DIGITS_DEF = 4;

  localparam int THR_W  = 16;
  localparam int UNIT_W = 24;
  localparam int TS_W   = 32;
  localparam int DIG_W  = 4;
  localparam int POS_W  = 2;
  localparam int REF_W  = 14;
  localparam int QUOT_W = 4;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd100;
  localparam logic [UNIT_W-1:0] UNIT_RST      = 24'd100000;

  // Quotient saturates here: eleven tenths or more is a pulse that is too long
  localparam logic [QUOT_W-1:0] QUOT_MAX = 4'd11;
  localparam logic [QUOT_W-1:0] QUOT_TEN = 4'd10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_TENTH = 1'b1;
  localparam int CFG_DATA_W = UNIT_W;

  typedef struct packed {
    logic [THR_W-1:0] discharge_time;
    logic [TS_W-1:0]  timestamp;
  } in_item_t;

  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic [POS_W-1:0] digit_position;
    logic             reference_done;
    logic [REF_W-1:0] reference;
    logic             pulse_too_long;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic set_light;   // latch pulse start, mark flash seen
    logic start_div;   // load elapsed time, clear flash mark
    logic div_step;    // subtract one unit from the remainder
    logic commit;      // decode quotient, update reference, load result
  } dp_cmd_t;

  typedef struct packed {
    logic lit;         // current input sample is lit
    logic light_seen;
    logic div_done;
    logic skip;        // leading zero: pulse ends with no result
    logic out_busy;    // result register full and not taken this cycle
  } dp_status_t;

endpackage

### src/flash_pulse_digit_decoder_top.sv
`timescale 1ns / 1ps
// Flash pulse digit decoder: one light sample per beat, at most one result.
// Lit samples and dark samples outside a flash leave the controller idle.
// A flash-ending sample goes to divide and evaluate, where no input is taken;
// the repeated-subtraction divider runs one step per cycle, up to 11 steps.
// Synchronous reset clears flash state, accumulator, result valid and restores
// register defaults (threshold 100, 100000 ticks per tenth).
module flash_pulse_digit_decoder_top #(
  parameter int DIGITS = fpdd_pkg::DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fpdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpdd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fpdd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fpdd_pkg::out_item_t             out_data
);
  import fpdd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fpdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fpdd_dp #(
    .DIGITS (DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### src/fpdd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences sample intake, serial divide and result.
// Depends on fpdd_pkg.
module fpdd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fpdd_pkg::dp_status_t status,
  output fpdd_pkg::dp_cmd_t    cmd
);
  import fpdd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.lit) begin
            cmd.set_light = !status.light_seen;
          end else if (status.light_seen) begin
            cmd.start_div = 1'b1;
            state_next    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_EVAL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EVAL: begin
        // hold until the result register is free; a skipped pulse returns to idle
        if (status.skip) begin
          state_next = ST_IDLE;
        end else if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/fpdd_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, flash state, serial divider by
// repeated subtraction, reference accumulator and result register. Uses fpdd_pkg.
module fpdd_dp #(
  parameter int DIGITS = fpdd_pkg::DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fpdd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpdd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fpdd_pkg::in_item_t                  in_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output fpdd_pkg::out_item_t                 out_data,
  input  fpdd_pkg::dp_cmd_t                   cmd,
  output fpdd_pkg::dp_status_t                status
);
  import fpdd_pkg::*;

  localparam int CNT_W = $clog2(DIGITS + 1);

  logic [THR_W-1:0]  light_threshold;
  logic [UNIT_W-1:0] ticks_per_tenth;
  logic              light_seen;
  logic [TS_W-1:0]   pulse_start;
  logic [TS_W-1:0]   rem;
  logic [QUOT_W-1:0] quot;
  logic [CNT_W-1:0]  digit_count;
  logic [REF_W-1:0]  reference_acc;

  logic [UNIT_W-1:0] unit;
  logic              rem_ge_unit;
  logic              too_long;
  logic [DIG_W-1:0]  dig;
  logic [REF_W-1:0]  acc_next;
  logic [CNT_W-1:0]  count_inc;
  logic              done;

  // a zero unit divides as one
  assign unit        = (ticks_per_tenth == '0) ? UNIT_W'(1) : ticks_per_tenth;
  assign rem_ge_unit = rem >= TS_W'(unit);

  assign too_long  = quot == QUOT_MAX;
  assign dig       = (quot == QUOT_TEN) ? '0 : DIG_W'(quot);
  assign acc_next  = {reference_acc[REF_W-4:0], 3'b000} + {reference_acc[REF_W-2:0], 1'b0}
                   + REF_W'(dig);
  assign count_inc = digit_count + CNT_W'(1);
  assign done      = count_inc == CNT_W'(DIGITS);

  assign status.lit        = in_data.discharge_time < light_threshold;
  assign status.light_seen = light_seen;
  assign status.div_done   = !rem_ge_unit || too_long;
  assign status.skip       = !too_long && (digit_count == '0) && (dig == '0);
  assign status.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold <= THRESHOLD_RST;
      ticks_per_tenth <= UNIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_THRESHOLD: light_threshold <= cfg_data[THR_W-1:0];
        REG_TICKS_PER_TENTH: ticks_per_tenth <= cfg_data[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_seen  <= 1'b0;
      pulse_start <= '0;
    end else if (cmd.set_light) begin
      light_seen  <= 1'b1;
      pulse_start <= in_data.timestamp;
    end else if (cmd.start_div) begin
      light_seen  <= 1'b0;
    end
  end

  // Serial divider: quotient is needed only up to eleven
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      rem  <= in_data.timestamp - pulse_start;
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem - TS_W'(unit);
      quot <= quot + QUOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= '0;
      reference_acc <= '0;
    end else if (cmd.commit && !too_long) begin
      if (done) begin
        digit_count   <= '0;
        reference_acc <= '0;
      end else begin
        digit_count   <= count_inc;
        reference_acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.digit_position <= POS_W'(digit_count);
      if (too_long) begin
        out_data.digit          <= '0;
        out_data.reference_done <= 1'b0;
        out_data.reference      <= reference_acc;
        out_data.pulse_too_long <= 1'b1;
      end else begin
        out_data.digit          <= dig;
        out_data.reference_done <= done;
        out_data.reference      <= acc_next;
        out_data.pulse_too_long <= 1'b0;
      end
    end
  end

endmodule

### src/fpdd_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the flash pulse digit decoder, bound to the top level.
// Depends on fpdd_pkg.
module fpdd_chk (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input fpdd_pkg::out_item_t out_data
);
  import fpdd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.digit <= DIG_W'(9))
    else $error("digit out of decimal range");

  a_too_long_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pulse_too_long |-> out_data.digit == '0 && !out_data.reference_done)
    else $error("dropped pulse carries a digit or completion");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind flash_pulse_digit_decoder_top fpdd_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
